// File: src/ffca_pkg.sv
// Package with shared types and codes for the first-fit coalescing allocator.
`timescale 1ns / 1ps

package ffca_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADSIZE = 2'd1;
    localparam logic [1:0] ST_NOFIT   = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_CHECK,
        S_A_RD,
        S_A_TEST,
        S_A_UNLINK,
        S_A_SPLIT,
        S_F_RD,
        S_F_TEST,
        S_P_START,
        S_P_RD,
        S_P_TEST,
        S_P_RDB,
        S_P_RDNX,
        S_P_MERGE,
        S_A_FINISH,
        S_OUT
    } state_t;

    typedef enum logic [4:0] {
        C_NONE,
        C_CLEAR,
        C_LOAD,
        C_A_CHECK,
        C_A_START,
        C_RD_CUR,
        C_A_ADV,
        C_A_UNLINK,
        C_A_SPLIT,
        C_F_START,
        C_F_COMMIT,
        C_P_START,
        C_P_RD,
        C_P_ADV,
        C_P_RDB,
        C_P_RDNX,
        C_P_MERGE,
        C_A_FINISH,
        C_FAIL_SIZE,
        C_FAIL_FIT,
        C_FAIL_FREE
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_free;
        logic a_size_bad;
        logic a_too_big;
        logic a_end;
        logic a_fits;
        logic a_split;
        logic f_bad;
        logic p_walk;
        logic from_alloc;
    } stat_t;

endpackage

// File: src/ffca_datapath.sv
// Datapath of the allocator: header memory, list pointers, counters and result.
`timescale 1ns / 1ps

module ffca_datapath #(
    parameter int POOL_BYTES   = 4096,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ffca_pkg::cmd_t     cmd,
    output ffca_pkg::stat_t    stat,
    input  logic               op,
    input  logic [15:0]        request_size,
    input  logic [11:0]        block_address,
    output logic [1:0]         status,
    output logic [11:0]        payload_address,
    output logic [11:0]        free_bytes,
    output logic [11:0]        min_free_bytes
);
    import ffca_pkg::*;

    localparam int HdrSpan  = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int EndOff   = ((POOL_BYTES - HdrSpan) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int EndG     = EndOff / ALIGN_BYTES;
    localparam int Granules = POOL_BYTES / ALIGN_BYTES + 1;
    localparam int GW       = $clog2(Granules + 1);
    localparam int SW       = $clog2(POOL_BYTES + 1) + 1;
    localparam int AW       = $clog2(Granules);
    localparam int WW       = 18;
    localparam int RecipSh  = WW + 6;
    localparam int RecipW   = RecipSh + 1;
    localparam int RecipM   = ((1 << RecipSh) + ALIGN_BYTES - 1) / ALIGN_BYTES;

    typedef struct packed {
        logic [SW-1:0] size;
        logic [GW-1:0] next;
        logic          alloc;
        logic          present;
    } hdr_t;

    // Division by the alignment through a reciprocal multiplication, exact
    // for every operand below 2**WW.
    function automatic logic [WW-1:0] div_align(input logic [WW-1:0] x);
        logic [WW+RecipW-1:0] p;
        p = (WW+RecipW)'(x) * (WW+RecipW)'(RecipM);
        return WW'(p >> RecipSh);
    endfunction

    hdr_t mem [Granules];
    hdr_t rd_q;

    localparam logic [GW-1:0] END_G_C = GW'(EndG);

    logic [GW-1:0] head_reg, head_next;
    logic [SW-1:0] fcnt_reg, fcnt_next, lcnt_reg, lcnt_next;
    logic [AW-1:0] clr_reg;
    logic [GW-1:0] prev_reg, cur_reg, b_reg, nx_reg;
    logic          prev_v_reg;
    logic [WW-1:0] want_reg;
    logic          op_reg;
    logic [15:0]   req_reg;
    logic [11:0]   addr_reg;
    hdr_t          cur_h_reg, b_h_reg, it_h_reg;
    logic [1:0]    st_reg;
    logic [11:0]   pay_reg;
    logic          alloc_ctx_reg;
    logic          f_bad_reg;

    logic          we;
    logic [AW-1:0] waddr;
    hdr_t          wdata;
    logic [AW-1:0] raddr;
    logic          re;

    logic [WW-1:0] want_c;
    logic [WW-1:0] want_q;
    logic [20:0]   h_w;
    logic [WW-1:0] h_q;
    logic          h_misal;
    logic [GW-1:0] g_w;
    logic [SW+WW-1:0] rem_w;
    logic [GW-1:0] ng_w;

    always_comb
    begin
        want_c = (WW'(req_reg) + WW'(HdrSpan) + WW'(ALIGN_BYTES - 1));
        want_q = div_align(want_c);
        want_c = WW'(want_q * WW'(ALIGN_BYTES));
        h_w = 21'(addr_reg) - 21'(HdrSpan);
        h_q = div_align(WW'(h_w));
        h_misal = (WW'(h_w) != WW'(h_q * WW'(ALIGN_BYTES)));
        g_w = GW'(h_q);
        rem_w = (SW+WW)'(cur_h_reg.size) - (SW+WW)'(want_reg);
        ng_w = cur_reg + GW'(div_align(want_reg));
    end

    logic f_bad_c;
    always_comb
    begin
        f_bad_c = 1'b0;
        if (addr_reg < 12'(HdrSpan))
        begin
            f_bad_c = 1'b1;
        end
        else if (h_misal)
        begin
            f_bad_c = 1'b1;
        end
        else if (g_w >= END_G_C)
        begin
            f_bad_c = 1'b1;
        end
    end

    // it_h_reg holds the predecessor's header; nx_reg the following free block.
    logic [SW+GW+8:0] it_end_w, b_end_w;
    always_comb
    begin
        it_end_w = (SW+GW+9)'(prev_reg) * (SW+GW+9)'(ALIGN_BYTES) + (SW+GW+9)'(it_h_reg.size);
        b_end_w  = (SW+GW+9)'(b_reg) * (SW+GW+9)'(ALIGN_BYTES) + (SW+GW+9)'(b_h_reg.size);
    end
    logic it_adj, b_adj;
    assign it_adj = prev_v_reg && (it_end_w == (SW+GW+9)'(b_reg) * (SW+GW+9)'(ALIGN_BYTES));
    assign b_adj  = (b_end_w == (SW+GW+9)'(nx_reg) * (SW+GW+9)'(ALIGN_BYTES));

    always_comb
    begin
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        re = 1'b0;
        raddr = '0;
        head_next = head_reg;
        fcnt_next = fcnt_reg;
        lcnt_next = lcnt_reg;
        unique case (cmd)
            C_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_reg;
                if (clr_reg == AW'(0))
                begin
                    wdata.size = SW'(EndOff);
                    wdata.next = END_G_C;
                    wdata.present = 1'b1;
                end
                else if (clr_reg == AW'(EndG))
                begin
                    wdata.next = END_G_C;
                    wdata.present = 1'b1;
                end
                head_next = '0;
                fcnt_next = SW'(EndOff);
                lcnt_next = SW'(EndOff);
            end
            C_A_START:
            begin
                re = 1'b1;
                raddr = AW'(head_reg);
            end
            C_RD_CUR:
            begin
                re = 1'b1;
                raddr = AW'(cur_reg);
            end
            C_A_UNLINK:
            begin
                if (!prev_v_reg)
                begin
                    head_next = rd_q.next;
                end
                else
                begin
                    we = 1'b1;
                    waddr = AW'(prev_reg);
                    wdata = it_h_reg;
                    wdata.next = rd_q.next;
                end
            end
            C_A_SPLIT:
            begin
                we = 1'b1;
                waddr = AW'(ng_w);
                wdata.size = SW'(rem_w);
                wdata.next = END_G_C;
                wdata.present = 1'b1;
            end
            C_F_START:
            begin
                re = 1'b1;
                raddr = AW'(g_w);
            end
            C_F_COMMIT:
            begin
                fcnt_next = fcnt_reg + rd_q.size;
            end
            C_P_START:
            begin
                if (head_reg < b_reg && head_reg < END_G_C)
                begin
                    re = 1'b1;
                    raddr = AW'(head_reg);
                end
            end
            C_P_RD:
            begin
                re = 1'b1;
                raddr = AW'(nx_reg);
            end
            C_P_RDB:
            begin
                re = 1'b1;
                raddr = AW'(b_reg);
            end
            C_P_RDNX:
            begin
                re = 1'b1;
                raddr = AW'(nx_reg);
            end
            C_P_MERGE:
            begin
                we = 1'b1;
                if (it_adj)
                begin
                    waddr = AW'(prev_reg);
                    wdata = it_h_reg;
                    wdata.size = it_h_reg.size + b_h_reg.size;
                end
                else
                begin
                    waddr = AW'(b_reg);
                    wdata = b_h_reg;
                end
                if (b_adj || (it_adj && (it_end_w + (SW+GW+9)'(b_h_reg.size)
                                        == (SW+GW+9)'(nx_reg) * (SW+GW+9)'(ALIGN_BYTES))))
                begin
                    if (nx_reg != END_G_C)
                    begin
                        wdata.size = wdata.size + rd_q.size;
                        wdata.next = rd_q.next;
                    end
                    else
                    begin
                        wdata.next = END_G_C;
                    end
                end
                else
                begin
                    wdata.next = nx_reg;
                end
                if (!prev_v_reg)
                begin
                    head_next = b_reg;
                end
            end
            C_A_FINISH:
            begin
                we = 1'b1;
                waddr = AW'(cur_reg);
                wdata = cur_h_reg;
                wdata.alloc = 1'b1;
                wdata.present = 1'b1;
                wdata.next = END_G_C;
                fcnt_next = fcnt_reg - cur_h_reg.size;
                if (fcnt_reg - cur_h_reg.size < lcnt_reg)
                begin
                    lcnt_next = fcnt_reg - cur_h_reg.size;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Second port write: clearing merged-away headers, the predecessor link and marking a freed header free.
    logic          we2;
    logic [AW-1:0] waddr2;
    hdr_t          wdata2;
    always_comb
    begin
        we2 = 1'b0;
        waddr2 = '0;
        wdata2 = '0;
        if (cmd == C_P_MERGE)
        begin
            if (it_adj)
            begin
                we2 = 1'b1;
                waddr2 = AW'(b_reg);
            end
            else if (prev_v_reg)
            begin
                we2 = 1'b1;
                waddr2 = AW'(prev_reg);
                wdata2 = it_h_reg;
                wdata2.next = b_reg;
            end
        end
        else if (cmd == C_F_COMMIT)
        begin
            we2 = 1'b1;
            waddr2 = AW'(g_w);
            wdata2 = rd_q;
            wdata2.alloc = 1'b0;
            wdata2.next = END_G_C;
        end
    end

    // Clearing of a merged next neighbor is done in the cycle after the merge.
    logic          pend_clr_reg;
    logic [AW-1:0] pend_addr_reg;
    logic          merge_nx;
    assign merge_nx = (cmd == C_P_MERGE) && nx_reg != END_G_C &&
        (b_adj || (it_adj && (it_end_w + (SW+GW+9)'(b_h_reg.size)
                              == (SW+GW+9)'(nx_reg) * (SW+GW+9)'(ALIGN_BYTES))));

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we2)
        begin
            mem[waddr2] <= wdata2;
        end
        else if (pend_clr_reg)
        begin
            mem[pend_addr_reg] <= '0;
        end
        if (re)
        begin
            rd_q <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fcnt_reg <= SW'(EndOff);
            lcnt_reg <= SW'(EndOff);
            clr_reg <= '0;
            pend_clr_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            fcnt_reg <= fcnt_next;
            lcnt_reg <= lcnt_next;
            if (cmd == C_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            pend_clr_reg <= merge_nx;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= AW'(nx_reg);
        unique case (cmd)
            C_LOAD:
            begin
                op_reg <= op;
                req_reg <= request_size;
                addr_reg <= block_address;
            end
            C_A_CHECK:
            begin
                want_reg <= want_c;
                prev_v_reg <= 1'b0;
                cur_reg <= head_reg;
                alloc_ctx_reg <= 1'b1;
            end
            C_A_ADV:
            begin
                prev_reg <= cur_reg;
                prev_v_reg <= 1'b1;
                it_h_reg <= rd_q;
                cur_reg <= rd_q.next;
            end
            C_A_UNLINK:
            begin
                cur_h_reg <= rd_q;
            end
            C_A_SPLIT:
            begin
                cur_h_reg.size <= SW'(want_reg);
                b_reg <= ng_w;
                b_h_reg.size <= SW'(rem_w);
                b_h_reg.next <= END_G_C;
                b_h_reg.alloc <= 1'b0;
                b_h_reg.present <= 1'b1;
            end
            C_F_START:
            begin
                alloc_ctx_reg <= 1'b0;
                b_reg <= g_w;
                f_bad_reg <= f_bad_c;
            end
            C_F_COMMIT:
            begin
                b_h_reg <= '{size: rd_q.size, next: END_G_C, alloc: 1'b0,
                             present: rd_q.present};
            end
            C_P_START:
            begin
                prev_v_reg <= 1'b0;
                nx_reg <= head_reg;
            end
            C_P_ADV:
            begin
                prev_reg <= nx_reg;
                prev_v_reg <= 1'b1;
                it_h_reg <= rd_q;
                nx_reg <= rd_q.next;
            end
            C_P_RDB:
            begin
                if (nx_reg > END_G_C)
                begin
                    nx_reg <= END_G_C;
                end
            end
            C_A_FINISH:
            begin
                st_reg <= ST_OK;
                pay_reg <= 12'((32'(cur_reg) * ALIGN_BYTES) + HdrSpan);
            end
            C_FAIL_SIZE:
            begin
                st_reg <= ST_BADSIZE;
                pay_reg <= '0;
            end
            C_FAIL_FIT:
            begin
                st_reg <= ST_NOFIT;
                pay_reg <= '0;
            end
            C_FAIL_FREE:
            begin
                st_reg <= ST_IGNORED;
                pay_reg <= '0;
            end
            C_P_MERGE:
            begin
                if (!alloc_ctx_reg)
                begin
                    st_reg <= ST_OK;
                    pay_reg <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.clear_done = (clr_reg == AW'(Granules - 1));
        stat.is_free    = (op_reg == OP_FREE);
        stat.a_size_bad = (req_reg == 16'd0);
        stat.a_too_big  = ((SW+WW)'(want_c) > (SW+WW)'(fcnt_reg));
        stat.a_end      = (cur_reg >= END_G_C);
        stat.a_fits     = ((SW+WW)'(rd_q.size) >= (SW+WW)'(want_reg));
        stat.a_split    = (rem_w > (SW+WW)'(2 * HdrSpan)) && (ng_w < END_G_C);
        stat.f_bad      = f_bad_reg || !rd_q.present || !rd_q.alloc;
        stat.p_walk     = (nx_reg < b_reg) && (nx_reg < END_G_C);
        stat.from_alloc = alloc_ctx_reg;
    end

    assign status          = st_reg;
    assign payload_address = pay_reg;
    assign free_bytes      = 12'(fcnt_reg);
    assign min_free_bytes  = 12'(lcnt_reg);
endmodule

// File: src/ffca_ctrl.sv
// Control state machine that sequences the header memory walks.
`timescale 1ns / 1ps

module ffca_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    input  ffca_pkg::stat_t stat,
    output ffca_pkg::cmd_t  cmd
);
    import ffca_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = C_NONE;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd = C_CLEAR;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd = C_LOAD;
                    state_next = S_A_CHECK;
                end
            end
            S_A_CHECK:
            begin
                if (stat.is_free)
                begin
                    cmd = C_F_START;
                    state_next = S_F_RD;
                end
                else if (stat.a_size_bad)
                begin
                    cmd = C_FAIL_SIZE;
                    state_next = S_OUT;
                end
                else if (stat.a_too_big)
                begin
                    cmd = C_FAIL_FIT;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd = C_A_CHECK;
                    state_next = S_A_RD;
                end
            end
            S_A_RD:
            begin
                if (stat.a_end)
                begin
                    cmd = C_FAIL_FIT;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd = C_RD_CUR;
                    state_next = S_A_TEST;
                end
            end
            S_A_TEST:
            begin
                if (stat.a_fits)
                begin
                    cmd = C_A_UNLINK;
                    state_next = S_A_UNLINK;
                end
                else
                begin
                    cmd = C_A_ADV;
                    state_next = S_A_RD;
                end
            end
            S_A_UNLINK:
            begin
                if (stat.a_split)
                begin
                    cmd = C_A_SPLIT;
                    state_next = S_P_START;
                end
                else
                begin
                    state_next = S_A_FINISH;
                end
            end
            S_A_FINISH:
            begin
                cmd = C_A_FINISH;
                state_next = S_OUT;
            end
            S_F_RD:
            begin
                cmd = C_F_START;
                state_next = S_F_TEST;
            end
            S_F_TEST:
            begin
                if (stat.f_bad)
                begin
                    cmd = C_FAIL_FREE;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd = C_F_COMMIT;
                    state_next = S_P_START;
                end
            end
            S_P_START:
            begin
                cmd = C_P_START;
                state_next = S_P_TEST;
            end
            S_P_TEST:
            begin
                if (stat.p_walk)
                begin
                    cmd = C_P_ADV;
                    state_next = S_P_RD;
                end
                else
                begin
                    cmd = C_P_RDB;
                    state_next = S_P_RDNX;
                end
            end
            S_P_RD:
            begin
                if (stat.p_walk)
                begin
                    cmd = C_P_RD;
                    state_next = S_P_TEST;
                end
                else
                begin
                    cmd = C_P_RDB;
                    state_next = S_P_RDNX;
                end
            end
            S_P_RDNX:
            begin
                cmd = C_P_RDNX;
                state_next = S_P_MERGE;
            end
            S_P_MERGE:
            begin
                cmd = C_P_MERGE;
                state_next = stat.from_alloc ? S_A_FINISH : S_OUT;
            end
            S_OUT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// File: src/first_fit_coalescing_allocator.sv
// Top level of the first-fit coalescing allocator.
`timescale 1ns / 1ps

// First-fit heap allocator over a header-only pool. After reset the block
// clears all POOL_BYTES / ALIGN_BYTES + 1 entries of its header memory and
// takes no word meanwhile. Each item then walks the address-ordered free
// list, reading one header at a time from the single header memory, and the
// next word is taken only once the result has been accepted; a free or split
// also walks the list to insert.
module first_fit_coalescing_allocator #(
    parameter int POOL_BYTES   = 4096,
    parameter int ALIGN_BYTES  = 8,
    parameter int HEADER_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // request_size, block_address
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // status, payload_address, free_bytes, min_free_bytes
);
    import ffca_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic [1:0]  status;
    logic [11:0] payload_address, free_bytes, min_free_bytes;

    ffca_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .stat(stat), .cmd(cmd)
    );

    ffca_datapath #(
        .POOL_BYTES(POOL_BYTES), .ALIGN_BYTES(ALIGN_BYTES), .HEADER_BYTES(HEADER_BYTES)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .op(s_axis_tuser), .request_size(s_axis_tdata[15:0]),
        .block_address(s_axis_tdata[27:16]),
        .status(status), .payload_address(payload_address),
        .free_bytes(free_bytes), .min_free_bytes(min_free_bytes)
    );

    assign m_axis_tdata = {2'b00, min_free_bytes, free_bytes, payload_address, status};
endmodule
